// ----- src/rsi_pkg.sv -----
// Shared constants and register codes for the ray and sphere intersection block.
package rsi_pkg;

	// Pipeline depth of the multiplier and the width of the operand slices that form its partial products.
	localparam int MUL_LAT = 4;
	localparam int MUL_CHUNK = 32;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CENTRE_X = 2'd0;
	localparam logic [1:0] CFG_CENTRE_Y = 2'd1;
	localparam logic [1:0] CFG_CENTRE_Z = 2'd2;
	localparam logic [1:0] CFG_RADIUS   = 2'd3;

endpackage

// ----- src/rsi_mul.sv -----
// Pipelined signed multiplier built from 32 by 32 bit partial products.
module rsi_mul import rsi_pkg::*; #(
	parameter int A_WIDTH = 33,
	parameter int B_WIDTH = 33
) (
	input  logic                             clk,
	input  logic                             adv,
	input  logic signed [A_WIDTH-1:0]        a,
	input  logic signed [B_WIDTH-1:0]        b,
	output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

	localparam int NA = (A_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int NB = (B_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int PW = A_WIDTH + B_WIDTH;

	logic [A_WIDTH-1:0] a_mag;
	logic [B_WIDTH-1:0] b_mag;
	logic [NA*MUL_CHUNK-1:0] am_s1;
	logic [NB*MUL_CHUNK-1:0] bm_s1;
	logic neg_s1, neg_s2, neg_s3;
	logic [2*MUL_CHUNK-1:0] pp_s2 [NA][NB];
	logic [PW-1:0] acc;
	logic [PW-1:0] sum_s3;
	logic signed [PW-1:0] p_s4;

	// Magnitudes; the most negative value maps onto its unsigned pattern.
	always_comb begin
		a_mag = a[A_WIDTH-1] ? A_WIDTH'(-a) : A_WIDTH'(a);
		b_mag = b[B_WIDTH-1] ? B_WIDTH'(-b) : B_WIDTH'(b);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= a[A_WIDTH-1] ^ b[B_WIDTH-1];
			am_s1 <= (NA*MUL_CHUNK)'(a_mag);
			bm_s1 <= (NB*MUL_CHUNK)'(b_mag);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2 <= neg_s1;
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= (2*MUL_CHUNK)'(am_s1[i*MUL_CHUNK +: MUL_CHUNK])
						* (2*MUL_CHUNK)'(bm_s1[j*MUL_CHUNK +: MUL_CHUNK]);
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (PW'(pp_s2[i][j]) << (MUL_CHUNK * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s3 <= neg_s2;
			sum_s3 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4 <= neg_s3 ? $signed(-sum_s3) : $signed(sum_s3);
		end
	end

	assign p = p_s4;

endmodule

// ----- src/rsi_solve.sv -----
// Discriminant, square root pipeline and long division pipeline for the nearer root.
module rsi_solve import rsi_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   adv,
	input  logic signed [2*(2*COORD_WIDTH+3)-1:0]  bb,
	input  logic signed [2*(2*COORD_WIDTH+3)-1:0]  ddk,
	input  logic signed [2*COORD_WIDTH+2:0]        b,
	input  logic [2*COORD_WIDTH-1:0]               dd,
	output logic [2*COORD_WIDTH+3+FRAC_BITS:0]     q,
	output logic                                   rem_nz,
	output logic                                   negn,
	output logic                                   hit
);

	localparam int BW   = 2*COORD_WIDTH + 3;
	localparam int DW   = 2*BW;
	localparam int DDW  = 2*COORD_WIDTH;
	localparam int SW   = BW;
	localparam int RW   = SW + 3;
	localparam int SQN  = BW;
	localparam int NUMW = BW + 2;
	localparam int NW   = NUMW - 1 + FRAC_BITS;
	localparam int DRW  = DDW + 1;

	logic signed [DW-1:0] disc;

	// Square root stages.
	logic [DW-1:0]        sq_x_s    [SQN+1];
	logic [SW-1:0]        sq_root_s [SQN+1];
	logic [RW-1:0]        sq_rem_s  [SQN+1];
	logic signed [BW-1:0] sq_b_s    [SQN+1];
	logic [DDW-1:0]       sq_dd_s   [SQN+1];
	logic                 sq_hit_s  [SQN+1];

	// Numerator stage.
	logic signed [NUMW-1:0] num_s;
	logic [DDW-1:0]         num_dd_s;
	logic                   num_hit_s;
	logic [NUMW-2:0]        num_mag;

	// Division stages.
	logic [NW-1:0]  dv_n_s   [NW+1];
	logic [NW-1:0]  dv_q_s   [NW+1];
	logic [DRW-1:0] dv_r_s   [NW+1];
	logic [DDW-1:0] dv_d_s   [NW+1];
	logic           dv_neg_s [NW+1];
	logic           dv_hit_s [NW+1];

	assign disc = bb - ddk;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s[0] <= disc[DW-1] ? '0 : disc;
			sq_root_s[0] <= '0;
			sq_rem_s[0] <= '0;
			sq_b_s[0] <= b;
			sq_dd_s[0] <= dd;
			sq_hit_s[0] <= (dd != '0) && !disc[DW-1];
		end
	end

	// Two radicand bits per stage, one root bit per stage.
	for (genvar k = 0; k < SQN; k++) begin : g_sqrt
		logic [RW-1:0] rem_nx;
		logic [RW-1:0] trial;
		logic          take;

		always_comb begin
			rem_nx = {sq_rem_s[k][RW-3:0], sq_x_s[k][DW-1 -: 2]};
			trial = RW'({sq_root_s[k], 2'b01});
			take = rem_nx >= trial;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_x_s[k+1] <= sq_x_s[k] << 2;
				sq_root_s[k+1] <= {sq_root_s[k][SW-2:0], take};
				sq_rem_s[k+1] <= take ? rem_nx - trial : rem_nx;
				sq_b_s[k+1] <= sq_b_s[k];
				sq_dd_s[k+1] <= sq_dd_s[k];
				sq_hit_s[k+1] <= sq_hit_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s <= -$signed(NUMW'(sq_b_s[SQN])) - $signed(NUMW'(sq_root_s[SQN]));
			num_dd_s <= sq_dd_s[SQN];
			num_hit_s <= sq_hit_s[SQN];
		end
	end

	assign num_mag = num_s[NUMW-1] ? (NUMW-1)'(-num_s) : (NUMW-1)'(num_s);

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_n_s[0] <= {num_mag, {FRAC_BITS{1'b0}}};
			dv_q_s[0] <= '0;
			dv_r_s[0] <= '0;
			dv_d_s[0] <= num_dd_s;
			dv_neg_s[0] <= num_s[NUMW-1];
			dv_hit_s[0] <= num_hit_s;
		end
	end

	// Restoring division, one quotient bit per stage.
	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [DRW-1:0] r_nx;
		logic           ge;

		always_comb begin
			r_nx = {dv_r_s[k][DRW-2:0], dv_n_s[k][NW-1]};
			ge = r_nx >= {1'b0, dv_d_s[k]};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_n_s[k+1] <= dv_n_s[k] << 1;
				dv_q_s[k+1] <= {dv_q_s[k][NW-2:0], ge};
				dv_r_s[k+1] <= ge ? r_nx - {1'b0, dv_d_s[k]} : r_nx;
				dv_d_s[k+1] <= dv_d_s[k];
				dv_neg_s[k+1] <= dv_neg_s[k];
				dv_hit_s[k+1] <= dv_hit_s[k];
			end
		end
	end

	assign q = dv_q_s[NW];
	assign rem_nz = dv_r_s[NW] != '0;
	assign negn = dv_neg_s[NW];
	assign hit = dv_hit_s[NW];

endmodule

// ----- src/ray_sphere_intersect.sv -----
// Top level of the ray and sphere intersection pipeline.
// A ray word carries origin and direction, each coordinate a signed fixed point value with
// FRAC_BITS fraction bits; the sphere centre and radius come from the configuration port
// and may only be changed while no ray is in flight. For each ray the block forms
// b = d.(e-c), d.d and the discriminant exactly, takes the integer square root and divides
// to give the nearer root t, rounded towards minus infinity and saturated to the
// coordinate range, with clipped set when saturation happened. A negative t is passed on
// as it is. A zero direction or a negative discriminant gives a word with hit, distance
// and clipped all zero. The pipeline takes one ray every clock while the output is not
// stalled and returns one result word per ray, in order. SQN is the number of square root
// stages (2*COORD_WIDTH+3, one root bit each) and NW the number of division stages
// (2*COORD_WIDTH+4+FRAC_BITS, one quotient bit each). The whole pipeline holds when the
// output word is not taken, so a stall loses nothing and the input is ready whenever the
// output register is empty or being read.
module ray_sphere_intersect import rsi_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from the lowest bit up
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// hit, distance, clipped from the lowest bit up
	output logic [((COORD_WIDTH+2+7)/8)*8-1:0] m_tdata,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);

	localparam int W    = COORD_WIDTH;
	localparam int FW   = W + 1;
	localparam int PW1  = 2*FW;
	localparam int BW   = 2*W + 3;
	localparam int DW   = 2*BW;
	localparam int DDW  = 2*W;
	localparam int SQN  = BW;
	localparam int NW   = BW + 1 + FRAC_BITS;
	localparam int SL   = 3 + SQN + NW;
	localparam int LAT  = 2*MUL_LAT + 5 + SL - 3 + 3;
	localparam int OUTW = ((W + 2 + 7) / 8) * 8;
	localparam int NMUL = 10;

	localparam logic [W-2:0] RAD_ONE = (W-1)'(1) << FRAC_BITS;
	localparam logic signed [NW:0] Q_MAX = {{(NW+2-W){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [NW:0] Q_MIN = ~Q_MAX;

	logic adv;

	// Sphere registers.
	logic signed [W-1:0] cx_q, cy_q, cz_q;
	logic [W-2:0]        rad_q;

	// Valid bits travel alongside the data.
	logic [LAT-1:0] vld_s;

	// Stage 1: offset from the centre and direction.
	logic signed [FW-1:0] fx_s1, fy_s1, fz_s1;
	logic signed [W-1:0]  dx_s1, dy_s1, dz_s1;
	logic [W-2:0]         rad_s1;

	logic signed [FW-1:0]  op_a [NMUL];
	logic signed [FW-1:0]  op_b [NMUL];
	logic signed [PW1-1:0] prod [NMUL];

	// Stage 2: dot products.
	logic signed [BW-1:0] b_s2, ff_s2, rr_s2;
	logic signed [BW-1:0] dd_sum;
	logic [DDW-1:0]       dd_s2;

	// Stage 3: |e-c|^2 - r^2.
	logic signed [BW-1:0] b_s3, k_s3;
	logic [DDW-1:0]       dd_s3;

	logic signed [BW-1:0] b_dl  [MUL_LAT];
	logic [DDW-1:0]       dd_dl [MUL_LAT];
	logic signed [DW-1:0] bb_p, ddk_p;

	logic [NW-1:0] q_raw;
	logic rem_nz, negn, hit_raw;

	// Stage 4: signed quotient, floored.
	logic signed [NW:0] qs_s4;
	logic               hit_s4;

	// Stage 5: output register.
	logic         hit_s5, clip_s5;
	logic [W-1:0] dist_s5;

	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			rad_q <= RAD_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTRE_X: cx_q <= cfg_data;
				CFG_CENTRE_Y: cy_q <= cfg_data;
				CFG_CENTRE_Z: cz_q <= cfg_data;
				CFG_RADIUS:   rad_q <= cfg_data[W-2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s1 <= FW'($signed(s_tdata[0*W +: W])) - FW'(cx_q);
			fy_s1 <= FW'($signed(s_tdata[1*W +: W])) - FW'(cy_q);
			fz_s1 <= FW'($signed(s_tdata[2*W +: W])) - FW'(cz_q);
			dx_s1 <= $signed(s_tdata[3*W +: W]);
			dy_s1 <= $signed(s_tdata[4*W +: W]);
			dz_s1 <= $signed(s_tdata[5*W +: W]);
			rad_s1 <= rad_q;
		end
	end

	// Ten products: d.f terms, d.d terms, f.f terms and r*r.
	always_comb begin
		op_a[0] = FW'(dx_s1);  op_b[0] = fx_s1;
		op_a[1] = FW'(dy_s1);  op_b[1] = fy_s1;
		op_a[2] = FW'(dz_s1);  op_b[2] = fz_s1;
		op_a[3] = FW'(dx_s1);  op_b[3] = FW'(dx_s1);
		op_a[4] = FW'(dy_s1);  op_b[4] = FW'(dy_s1);
		op_a[5] = FW'(dz_s1);  op_b[5] = FW'(dz_s1);
		op_a[6] = fx_s1;       op_b[6] = fx_s1;
		op_a[7] = fy_s1;       op_b[7] = fy_s1;
		op_a[8] = fz_s1;       op_b[8] = fz_s1;
		op_a[9] = $signed({2'b00, rad_s1});
		op_b[9] = $signed({2'b00, rad_s1});
	end

	for (genvar m = 0; m < NMUL; m++) begin : g_mul1
		rsi_mul #(
			.A_WIDTH(FW),
			.B_WIDTH(FW)
		) u_mul (
			.clk(clk),
			.adv(adv),
			.a(op_a[m]),
			.b(op_b[m]),
			.p(prod[m])
		);
	end

	assign dd_sum = BW'(prod[3]) + BW'(prod[4]) + BW'(prod[5]);

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s2 <= BW'(prod[0]) + BW'(prod[1]) + BW'(prod[2]);
			dd_s2 <= dd_sum[DDW-1:0];
			ff_s2 <= BW'(prod[6]) + BW'(prod[7]) + BW'(prod[8]);
			rr_s2 <= BW'(prod[9]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s3 <= b_s2;
			dd_s3 <= dd_s2;
			k_s3 <= ff_s2 - rr_s2;
		end
	end

	// b and d.d wait alongside the second multiplier row.
	always_ff @(posedge clk) begin
		if (adv) begin
			b_dl[0] <= b_s3;
			dd_dl[0] <= dd_s3;
			for (int i = 1; i < MUL_LAT; i++) begin
				b_dl[i] <= b_dl[i-1];
				dd_dl[i] <= dd_dl[i-1];
			end
		end
	end

	rsi_mul #(
		.A_WIDTH(BW),
		.B_WIDTH(BW)
	) u_mul_bb (
		.clk(clk),
		.adv(adv),
		.a(b_s3),
		.b(b_s3),
		.p(bb_p)
	);

	rsi_mul #(
		.A_WIDTH(BW),
		.B_WIDTH(BW)
	) u_mul_ddk (
		.clk(clk),
		.adv(adv),
		.a($signed(BW'(dd_s3))),
		.b(k_s3),
		.p(ddk_p)
	);

	rsi_solve #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_solve (
		.clk(clk),
		.adv(adv),
		.bb(bb_p),
		.ddk(ddk_p),
		.b(b_dl[MUL_LAT-1]),
		.dd(dd_dl[MUL_LAT-1]),
		.q(q_raw),
		.rem_nz(rem_nz),
		.negn(negn),
		.hit(hit_raw)
	);

	// A negative quotient with a remainder rounds one further down.
	always_ff @(posedge clk) begin
		if (adv) begin
			qs_s4 <= negn ? -($signed((NW+1)'(q_raw)) + $signed((NW+1)'(rem_nz)))
				: $signed((NW+1)'(q_raw));
			hit_s4 <= hit_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s5 <= hit_s4;
			if (!hit_s4) begin
				dist_s5 <= '0;
				clip_s5 <= 1'b0;
			end else if (qs_s4 > Q_MAX) begin
				dist_s5 <= Q_MAX[W-1:0];
				clip_s5 <= 1'b1;
			end else if (qs_s4 < Q_MIN) begin
				dist_s5 <= Q_MIN[W-1:0];
				clip_s5 <= 1'b1;
			end else begin
				dist_s5 <= qs_s4[W-1:0];
				clip_s5 <= 1'b0;
			end
		end
	end

	assign m_tvalid = vld_s[LAT-1];
	assign m_tdata = OUTW'({clip_s5, dist_s5, hit_s5});

endmodule

// ----- sim/tb_ray_sphere_intersect.sv -----
// Self-checking testbench for the ray and sphere intersection pipeline.
`timescale 1ns / 100ps

module tb_ray_sphere_intersect;
	import rsi_pkg::*;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int LATENCY = 167;
	localparam longint CYCLE_LIMIT = 2000000;

	// Result of one ray as the block should report it.
	typedef struct packed {
		logic hit;
		logic signed [CW-1:0] distance;
		logic clipped;
	} hit_word_t;

	// Keeps the sphere registers, predicts each ray's result and checks the returned words.
	class intersect_scoreboard;
		logic signed [CW-1:0] cx, cy, cz;
		logic [CW-2:0] radius;
		hit_word_t pending[$];
		int errors;

		function new();
			cx = '0;
			cy = '0;
			cz = '0;
			radius = 31'd65536;
			errors = 0;
		endfunction

		// Integer square root, rounded down, by one bit per step.
		function automatic logic [255:0] isqrt(logic [255:0] x);
			logic [255:0] res, cand;
			res = '0;
			for (int i = 127; i >= 0; i--) begin
				cand = res | (256'd1 << i);
				if (cand * cand <= x)
					res = cand;
			end
			return res;
		endfunction

		// Works out the expected result of a ray from the current sphere.
		function void note_ray(logic [6*CW-1:0] ray);
			logic signed [255:0] fx, fy, fz, dx, dy, dz, b, dd, k, disc, num, q, mag, rr;
			logic signed [255:0] maxv, minv;
			hit_word_t w;
			fx = $signed(ray[0*CW +: CW]) - $signed(cx);
			fy = $signed(ray[1*CW +: CW]) - $signed(cy);
			fz = $signed(ray[2*CW +: CW]) - $signed(cz);
			dx = $signed(ray[3*CW +: CW]);
			dy = $signed(ray[4*CW +: CW]);
			dz = $signed(ray[5*CW +: CW]);
			rr = $signed({225'd0, radius});
			b = dx * fx + dy * fy + dz * fz;
			dd = dx * dx + dy * dy + dz * dz;
			k = fx * fx + fy * fy + fz * fz - rr * rr;
			disc = b * b - dd * k;
			w = '0;
			if (dd != 0 && disc >= 0) begin
				num = (-b - $signed(isqrt(disc))) <<< FB;
				// Division rounded towards minus infinity.
				if (num < 0) begin
					mag = -num;
					q = mag / dd;
					if (q * dd != mag)
						q = q + 1;
					q = -q;
				end else begin
					q = num / dd;
				end
				maxv = (256'sd1 <<< (CW - 1)) - 1;
				minv = -(256'sd1 <<< (CW - 1));
				w.hit = 1'b1;
				if (q > maxv) begin
					q = maxv;
					w.clipped = 1'b1;
				end else if (q < minv) begin
					q = minv;
					w.clipped = 1'b1;
				end
				w.distance = q[CW-1:0];
			end
			pending.push_back(w);
		endfunction

		// Compares one returned word with the oldest expectation.
		function void check_word(logic [CW+1:0] data);
			hit_word_t w;
			if (pending.size() == 0) begin
				$error("unexpected result word %h", data);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (data[0] !== w.hit) begin
				$error("hit: expected %0d, got %0d", w.hit, data[0]);
				errors++;
			end
			if (data[CW:1] !== w.distance) begin
				$error("distance: expected %0d, got %0d", w.distance, $signed(data[CW:1]));
				errors++;
			end
			if (data[CW+1] !== w.clipped) begin
				$error("clipped: expected %0d, got %0d", w.clipped, data[CW+1]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [6*CW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [((CW+2+7)/8)*8-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;

	intersect_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycle_count = 0;

	ray_sphere_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (.*);

	always #2 clk = ~clk;

	// The receiver stalls at random; a fresh choice is made every falling edge.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata[CW+1:0]);
	end

	// A run that has not finished by the limit has hung somewhere.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Writes one sphere register while the pipeline is empty.
	task automatic write_reg(logic [1:0] idx, logic [CW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CENTRE_X: sb.cx = val;
			CFG_CENTRE_Y: sb.cy = val;
			CFG_CENTRE_Z: sb.cz = val;
			CFG_RADIUS: sb.radius = val[CW-2:0];
			default: ;
		endcase
	endtask

	task automatic set_sphere(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
			logic [CW-1:0] r);
		write_reg(CFG_CENTRE_X, x);
		write_reg(CFG_CENTRE_Y, y);
		write_reg(CFG_CENTRE_Z, z);
		write_reg(CFG_RADIUS, r);
	endtask

	// Presents one ray word and holds it until the block takes it.
	task automatic send_ray(logic [6*CW-1:0] ray);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ray;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_ray(ray);
		@(negedge clk);
	endtask

	// Waits until every word has come back, then lets the pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord(int spread);
		case ($urandom_range(3))
			0: return $urandom();
			1: return CW'($signed($urandom_range(2 * spread)) - spread) <<< FB;
			2: return CW'($signed($urandom_range(65535)) - 32768) <<< ($urandom_range(12));
			default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
		endcase
	endfunction

	// A ray aimed roughly at the current centre, so that most of them hit.
	function automatic logic [6*CW-1:0] aimed_ray();
		logic [CW-1:0] o[3], d[3];
		int off;
		for (int i = 0; i < 3; i++) begin
			off = ($signed($urandom_range(40)) - 20) <<< FB;
			o[i] = (i == 0 ? sb.cx : i == 1 ? sb.cy : sb.cz) + off;
			d[i] = -off + (($signed($urandom_range(4096)) - 2048) <<< 4);
		end
		return {d[2], d[1], d[0], o[2], o[1], o[0]};
	endfunction

	function automatic logic [6*CW-1:0] random_ray();
		logic [6*CW-1:0] ray;
		if ($urandom_range(99) < 65)
			return aimed_ray();
		for (int i = 0; i < 6; i++)
			ray[i*CW +: CW] = rand_coord(100);
		if ($urandom_range(19) == 0)
			ray[3*CW +: 3*CW] = '0;
		return ray;
	endfunction

	initial begin
		logic [CW-1:0] one;
		one = 32'h0001_0000;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rays against the reset sphere: a unit sphere at the origin.
		send_ray({96'd0, 32'h0005_0000, 64'd0});                       // zero direction
		send_ray({64'd0, one, 64'd0, -32'sh0005_0000});               // hit from behind
		send_ray({64'd0, one, 64'd0, 32'h0005_0000});                 // negative t
		send_ray({64'd0, one, 32'h0001_0000, 32'd0, -32'sh0005_0000}); // tangent
		send_ray({64'd0, one, 32'h0002_0000, 32'd0, -32'sh0005_0000}); // miss
		send_ray({64'd0, 32'd1, 64'd0, 32'h8000_0000});               // far hit, clipped high
		send_ray({64'd0, 32'd1, 64'd0, 32'h7fff_ffff});               // clipped low
		send_ray({{3{32'h7fff_ffff}}, {3{32'h8000_0000}}});
		send_ray({{3{32'h8000_0000}}, {3{32'h7fff_ffff}}});
		send_ray({{3{32'hffff_ffff}}, {3{32'd0}}});
		send_ray({6{32'h5555_5555}});
		send_ray({6{32'haaaa_aaaa}});
		drain();

		// Extreme sphere settings.
		set_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_ray({{3{32'h8000_0000}}, {3{32'd0}}});
		send_ray({{3{32'h7fff_ffff}}, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
		send_ray({6{32'h1234_5678}});
		drain();
		set_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
		send_ray({64'd0, one, {3{32'h8000_0000}}});
		send_ray({{3{32'h7fff_ffff}}, {3{32'h7fff_ffff}}});
		send_ray({{3{32'hffff_ffff}}, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
		drain();

		// Random rays through the idling phases, each with a new sphere.
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 79 : 37) : 0;
			recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 79 : 37) : 0;
			set_sphere(rand_coord(50), rand_coord(50), rand_coord(50),
				phase == 0 ? 32'd0 : {1'b0, 31'($urandom_range(20) <<< FB)});
			for (int n = 0; n < 260; n++)
				send_ray(random_ray());
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_sphere(rand_coord(50), rand_coord(50), rand_coord(50), {1'b0, 31'($urandom())});
		for (int n = 0; n < 40; n++)
			send_ray(random_ray());
		drain();

		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
